/* sv/terminal_key_sequence_decoder_top_defines.svh */
// assertion macros shared by the terminal key decoder rtl
`ifndef TERMINAL_KEY_SEQUENCE_DECODER_TOP_DEFINES_SVH
`define TERMINAL_KEY_SEQUENCE_DECODER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// checked outside reset
`define TKD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define TKD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define TKD_ASSERT(label, prop, msg)
`define TKD_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

/* sv/tkd_pkg.sv */
// shared constants and types for the terminal key sequence decoder
`timescale 1ns / 1ps

package tkd_pkg;

    localparam int NUMBER_BITS_DEF = 16;
    localparam int NUMBER_VALUE_W  = 16;
    localparam int KEY_CLASS_W     = 3;

    localparam logic [7:0] BYTE_ESC     = 8'd27;
    localparam logic [7:0] BYTE_DEL     = 8'd127;
    localparam logic [7:0] LAST_CONTROL = 8'd26;
    localparam logic [7:0] CTRL_H_BYTE  = 8'd8;
    localparam logic [7:0] BYTE_BRACKET = 8'h5B;
    localparam logic [7:0] BYTE_Q       = 8'h71;
    localparam logic [7:0] BYTE_ZERO    = 8'h30;
    localparam logic [7:0] BYTE_NINE    = 8'h39;
    localparam logic [7:0] CTRL_BASE    = 8'h40;
    localparam logic [7:0] CTRL_LAST    = 8'h5A;

    typedef enum logic [KEY_CLASS_W-1:0] {
        KC_PLAIN       = 3'd0,
        KC_CONTROL     = 3'd1,
        KC_ESC         = 3'd2,
        KC_ESC_DIGIT   = 3'd3,
        KC_BRACKET_NUM = 3'd4,
        KC_BRACKET_ALP = 3'd5
    } t_key_class;

endpackage

/* sv/terminal_key_sequence_decoder_top.sv */
// top level of the terminal key sequence decoder
`timescale 1ns / 1ps
`include "terminal_key_sequence_decoder_top_defines.svh"

// Decodes a stream of terminal input bytes into keys, one byte per item. Plain
// bytes (including 28..31 and 128..255) come back as themselves with class 0;
// bytes 0..26 and DEL (treated as Ctrl-H) come back as control keys mapped to
// '@'+byte; ESC x y gives class 2 (class 3 when x is a digit); ESC [ y gives
// class 5 with y; ESC [ digits y gives class 4 with y and the decimal value,
// saturating at 2^NUMBER_BITS-1 and reported in its low 16 bits. Bytes that
// only extend an unfinished sequence give no result item. quit_key flags a
// plain 'q'; decoding simply carries on. Rate: one byte per clock sustained
// while the output is not stalled. A byte lands in an input register; as it
// moves on, the phase register, digit accumulator and output register update
// from it, so a result item is registered once its final byte moves on. The
// output register can be stalled while the next byte is already taken in.
module terminal_key_sequence_decoder_top #(
    parameter int NUMBER_BITS = tkd_pkg::NUMBER_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input byte channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [7:0]                          i_rx_byte,
    // result item channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [tkd_pkg::KEY_CLASS_W-1:0]     o_key_class,
    output logic [7:0]                          o_key_char,
    output logic [tkd_pkg::NUMBER_VALUE_W-1:0]  o_number_value,
    output logic                                o_quit_key
);

    // parse phases, unused codes fall back to idle
    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_ESC       = 3'd1,
        PH_ESC_DIGIT = 3'd2,
        PH_ESC_OTHER = 3'd3,
        PH_BRACKET   = 3'd4,
        PH_DIGITS    = 3'd5
    } t_phase;

    localparam int SUM_W = NUMBER_BITS + 4;
    localparam logic [SUM_W-1:0] NUM_LIMIT = {4'b0000, {NUMBER_BITS{1'b1}}};

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // decoder state
    t_phase                 r_phase;
    t_phase                 n_phase;
    logic [NUMBER_BITS-1:0] r_acc;
    logic [NUMBER_BITS-1:0] n_acc;

    // output register
    logic                                r_out_valid;
    tkd_pkg::t_key_class                 r_out_class;
    logic [7:0]                          r_out_char;
    logic [tkd_pkg::NUMBER_VALUE_W-1:0]  r_out_number;
    logic                                r_out_quit;

    // decode of the byte held in the input register
    logic                                w_emit;
    tkd_pkg::t_key_class                 w_class;
    logic [7:0]                          w_char;
    logic [tkd_pkg::NUMBER_VALUE_W-1:0]  w_number;

    logic                                w_out_free;
    logic                                w_advance;
    logic                                w_is_digit;
    logic [3:0]                          w_digit;
    logic [SUM_W-1:0]                    w_sum;
    logic [NUMBER_BITS-1:0]              w_acc_next;
    logic [7:0]                          w_plain_byte;
    logic [tkd_pkg::NUMBER_VALUE_W-1:0]  w_acc_low;

    // handshake: the held byte moves on whenever the output slot can take a result
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_advance  = r_in_valid && w_out_free;
    assign o_stall    = r_in_valid && !w_out_free;

    // digit detection and saturating times-ten accumulate
    assign w_is_digit = (r_in_byte >= tkd_pkg::BYTE_ZERO) && (r_in_byte <= tkd_pkg::BYTE_NINE);
    assign w_digit    = 4'(r_in_byte - tkd_pkg::BYTE_ZERO);
    assign w_sum      = ({4'b0000, r_acc} << 3) + ({4'b0000, r_acc} << 1)
                      + SUM_W'(w_digit);
    assign w_acc_next = (w_sum > NUM_LIMIT) ? {NUMBER_BITS{1'b1}} : w_sum[NUMBER_BITS-1:0];

    // DEL becomes Ctrl-H before the control check
    assign w_plain_byte = (r_in_byte == tkd_pkg::BYTE_DEL) ? tkd_pkg::CTRL_H_BYTE : r_in_byte;

    // low bits of the accumulator as the reported parameter
    generate
        if (NUMBER_BITS >= tkd_pkg::NUMBER_VALUE_W) begin : g_num_trunc
            assign w_acc_low = r_acc[tkd_pkg::NUMBER_VALUE_W-1:0];
        end else begin : g_num_ext
            assign w_acc_low = {{(tkd_pkg::NUMBER_VALUE_W-NUMBER_BITS){1'b0}}, r_acc};
        end
    endgenerate

    // next phase and result for the held byte
    always_comb begin
        n_phase  = PH_IDLE;
        n_acc    = r_acc;
        w_emit   = 1'b0;
        w_class  = tkd_pkg::KC_PLAIN;
        w_char   = r_in_byte;
        w_number = '0;
        unique case (r_phase)
            PH_ESC: begin
                if (r_in_byte == tkd_pkg::BYTE_BRACKET) begin
                    n_phase = PH_BRACKET;
                end else if (w_is_digit) begin
                    n_phase = PH_ESC_DIGIT;
                end else begin
                    n_phase = PH_ESC_OTHER;
                end
            end
            PH_ESC_DIGIT: begin
                w_emit  = 1'b1;
                w_class = tkd_pkg::KC_ESC_DIGIT;
            end
            PH_ESC_OTHER: begin
                w_emit  = 1'b1;
                w_class = tkd_pkg::KC_ESC;
            end
            PH_BRACKET: begin
                if (w_is_digit) begin
                    // first digit, cannot saturate
                    n_acc   = NUMBER_BITS'(w_digit);
                    n_phase = PH_DIGITS;
                end else begin
                    w_emit  = 1'b1;
                    w_class = tkd_pkg::KC_BRACKET_ALP;
                end
            end
            PH_DIGITS: begin
                if (w_is_digit) begin
                    n_acc   = w_acc_next;
                    n_phase = PH_DIGITS;
                end else begin
                    w_emit   = 1'b1;
                    w_class  = tkd_pkg::KC_BRACKET_NUM;
                    w_number = w_acc_low;
                end
            end
            default: begin
                // idle, or an unused code treated as idle
                if (r_in_byte == tkd_pkg::BYTE_ESC) begin
                    n_phase = PH_ESC;
                end else if (w_plain_byte <= tkd_pkg::LAST_CONTROL) begin
                    w_emit  = 1'b1;
                    w_class = tkd_pkg::KC_CONTROL;
                    w_char  = tkd_pkg::CTRL_BASE + w_plain_byte;
                end else begin
                    w_emit  = 1'b1;
                    w_class = tkd_pkg::KC_PLAIN;
                    w_char  = w_plain_byte;
                end
            end
        endcase
    end

    // input register, phase, accumulator and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_phase     <= PH_IDLE;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // take a new byte when the input register is empty or moving on
            if (!r_in_valid || w_advance) begin
                r_in_valid <= i_valid;
                r_in_byte  <= i_rx_byte;
            end
            if (w_advance) begin
                r_phase <= n_phase;
                r_acc   <= n_acc;
            end
            if (w_out_free) begin
                r_out_valid <= w_advance && w_emit;
            end
            if (w_advance && w_emit) begin
                r_out_class  <= w_class;
                r_out_char   <= w_char;
                r_out_number <= w_number;
                r_out_quit   <= (w_class == tkd_pkg::KC_PLAIN) && (w_char == tkd_pkg::BYTE_Q);
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_key_class    = r_out_class;
    assign o_key_char     = r_out_char;
    assign o_number_value = r_out_number;
    assign o_quit_key     = r_out_quit;

    // a finished key always returns the parser to idle
    `TKD_ASSERT(a_idle_after_key, (w_advance && w_emit) |=> (r_phase == PH_IDLE), "phase not idle after key")
    // quit only for a plain key
    `TKD_ASSERT(a_quit_plain, (r_out_valid && r_out_quit) |-> (r_out_class == tkd_pkg::KC_PLAIN), "quit on non-plain key")
    // parameter is zero outside the bracket number class
    `TKD_ASSERT(a_number_class, (r_out_valid && (r_out_class != tkd_pkg::KC_BRACKET_NUM)) |-> (r_out_number == '0), "number outside bracket number class")
    // control keys map onto '@'..'Z'
    `TKD_ASSERT(a_control_range, (r_out_valid && (r_out_class == tkd_pkg::KC_CONTROL)) |-> ((r_out_char >= tkd_pkg::CTRL_BASE) && (r_out_char <= tkd_pkg::CTRL_LAST)), "control key out of range")
    // reset leaves no item in flight and the parser idle
    `TKD_ASSERT_ALWAYS(a_reset_clear, !i_rst_n |=> (!r_out_valid && !r_in_valid && (r_phase == PH_IDLE)), "reset did not clear")

endmodule
